FILE: design/ppmfd_pkg.sv
// shared types and constants for the ppm frame decoder
package ppmfd_pkg;

  localparam int TIME_W   = 32;
  localparam int WIDTH_W  = 16;
  localparam int INDEX_W  = 3;
  localparam int COUNT_W  = 4;

  localparam logic [WIDTH_W-1:0] SYNC_RESET = 16'd3000;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               rising;
    logic               gap;
    logic [WIDTH_W-1:0] interval;
  } edge_evt_t;

endpackage

FILE: design/ppmfd_edge_if.sv
// edge event channel and frame result channel
interface ppmfd_edge_if;
  logic                          valid;
  logic                          ready;
  logic [ppmfd_pkg::TIME_W-1:0]  edge_time;
  logic                          level_high;

  modport source (output valid, output edge_time, output level_high, input ready);
  modport sink (input valid, input edge_time, input level_high, output ready);
endinterface

interface ppmfd_result_if;
  logic                          valid;
  logic                          ready;
  logic [ppmfd_pkg::INDEX_W-1:0] channel_index;
  logic [ppmfd_pkg::WIDTH_W-1:0] channel_width;
  logic [ppmfd_pkg::COUNT_W-1:0] frame_count;
  logic                          frame_overflow;
  logic                          last_of_frame;

  modport source (output valid, output channel_index, output channel_width,
                  output frame_count, output frame_overflow, output last_of_frame,
                  input ready);
  modport sink (input valid, input channel_index, input channel_width,
                input frame_count, input frame_overflow, input last_of_frame,
                output ready);
endinterface

FILE: design/ppmfd_interval.sv
// interval accumulator between edges and frame gap compare
module ppmfd_interval (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [ppmfd_pkg::WIDTH_W-1:0] now,
  input  logic                          level_high,
  input  logic                          cfg_we,
  input  logic [ppmfd_pkg::WIDTH_W-1:0] cfg_wdata,
  output ppmfd_pkg::edge_evt_t          evt
);

  logic [ppmfd_pkg::WIDTH_W-1:0] prev_time;
  logic [ppmfd_pkg::WIDTH_W-1:0] interval_sum;
  logic [ppmfd_pkg::WIDTH_W-1:0] sync_threshold;
  logic [ppmfd_pkg::WIDTH_W-1:0] sum_next;

  assign sum_next     = interval_sum + (now - prev_time);
  assign evt.rising   = level_high;
  assign evt.interval = sum_next;
  assign evt.gap      = (sum_next >= sync_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time      <= '0;
      interval_sum   <= '0;
      sync_threshold <= ppmfd_pkg::SYNC_RESET;
    end else begin
      if (cfg_we) begin
        sync_threshold <= cfg_wdata;
      end
      if (take) begin
        prev_time    <= now;
        interval_sum <= level_high ? '0 : sum_next;
      end
    end
  end

endmodule

FILE: design/ppm_frame_decoder.sv
// ppm frame decoder top level: channel width store and frame readout
// an edge transfer is taken while no frame is being read out
// a sync edge with n stored channels reads max(n,1) results out of the width memory
// sync edge, then state reg, then output reg; one result per cycle while slot_free
// the next edge is taken once the last result of the frame is in the output register
// reset clears counts, interval state and threshold (3000); width memory is not cleared
module ppm_frame_decoder #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  ppmfd_edge_if.sink                    edges,
  ppmfd_result_if.source                results,
  input  logic                          cfg_we,
  input  logic [ppmfd_pkg::WIDTH_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  ppmfd_pkg::state_t    state, state_next;
  ppmfd_pkg::edge_evt_t evt;

  logic                          take;
  logic [CNT_W-1:0]              count;
  logic                          ovf;
  logic [CNT_W-1:0]              fcount;
  logic                          fovf;
  logic [IDX_W-1:0]              ptr, ptr_next;
  logic [IDX_W-1:0]              raddr;
  logic [ppmfd_pkg::WIDTH_W-1:0] rdata;
  logic                          wr_en;
  logic                          full;
  logic                          slot_free;
  logic                          load;
  logic                          is_last;

  logic [ppmfd_pkg::WIDTH_W-1:0] width_mem [MAX_CHANNELS];

  logic                          res_valid;
  logic [ppmfd_pkg::INDEX_W-1:0] res_index;
  logic [ppmfd_pkg::WIDTH_W-1:0] res_width;
  logic [ppmfd_pkg::COUNT_W-1:0] res_count;
  logic                          res_ovf;
  logic                          res_last;

  ppmfd_interval u_interval (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .now        (edges.edge_time[ppmfd_pkg::WIDTH_W-1:0]),
    .level_high (edges.level_high),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .evt        (evt)
  );

  assign edges.ready = (state == ppmfd_pkg::ST_IDLE);
  assign take        = edges.valid && edges.ready;
  assign full        = (count == CNT_W'(MAX_CHANNELS));
  assign wr_en       = take && evt.rising && !evt.gap && !full;
  assign slot_free   = !res_valid || results.ready;
  assign is_last     = (fcount == '0) || (CNT_W'(ptr) + CNT_W'(1) == fcount);

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    raddr      = '0;
    load       = 1'b0;
    unique case (state)
      ppmfd_pkg::ST_IDLE: begin
        if (take && evt.rising && evt.gap) begin
          state_next = ppmfd_pkg::ST_EMIT;
          ptr_next   = '0;
        end
      end
      ppmfd_pkg::ST_EMIT: begin
        raddr = ptr;
        if (slot_free) begin
          load = 1'b1;
          if (is_last) begin
            state_next = ppmfd_pkg::ST_IDLE;
          end else begin
            ptr_next = ptr + IDX_W'(1);
            raddr    = ptr_next;
          end
        end
      end
      default: begin
        state_next = ppmfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppmfd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      width_mem[count[IDX_W-1:0]] <= evt.interval;
    end
    rdata <= width_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ovf    <= 1'b0;
      fcount <= '0;
      fovf   <= 1'b0;
      ptr    <= '0;
    end else begin
      ptr <= ptr_next;
      if (take && evt.rising) begin
        if (evt.gap) begin
          fcount <= count;
          fovf   <= ovf;
          count  <= '0;
          ovf    <= 1'b0;
        end else if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_index <= ppmfd_pkg::INDEX_W'(ptr);
      res_width <= (fcount == '0) ? '0 : rdata;
      res_count <= ppmfd_pkg::COUNT_W'(fcount);
      res_ovf   <= fovf;
      res_last  <= is_last;
    end
  end

  assign results.valid          = res_valid;
  assign results.channel_index  = res_index;
  assign results.channel_width  = res_width;
  assign results.frame_count    = res_count;
  assign results.frame_overflow = res_ovf;
  assign results.last_of_frame  = res_last;

endmodule
